// ===== design/elc_pkg.sv =====
// ----------------------------------------------------------------------------
// elc_pkg
// Shared types, codes and helpers for the LOOK elevator car controller.
// ----------------------------------------------------------------------------
package elc_pkg;

  // default number of floors the bitmap can hold
  localparam int DEFAULT_MAX_FLOORS = 16;

  // fixed field widths
  localparam int FLOOR_W = 4;
  localparam int FIU_W   = 5;
  localparam int DIR_W   = 2;

  // reset value of the floor count register
  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

  // item command codes
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // travel direction
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // scan summary handed from the scan unit to the sequencer
  typedef struct packed {
    logic               lo_found;
    logic [FLOOR_W-1:0] lo;
    logic               hi_found;
    logic [FLOOR_W-1:0] hi;
  } scan_res_t;

  // effective floor count: zero acts as one, clamp at the bitmap size
  function automatic int eff_floors(input logic [FIU_W-1:0] fiu, input int max_floors);
    int n;
    n = int'(fiu);
    if (n < 1) begin
      n = 1;
    end else if (n > max_floors) begin
      n = max_floors;
    end
    return n;
  endfunction

endpackage

// ===== design/elc_scan.sv =====
// ----------------------------------------------------------------------------
// elc_scan
// Floor scanner: walks the request bitmap one floor per cycle and keeps the
// lowest request and the highest request at or above the car.
// ----------------------------------------------------------------------------
module elc_scan #(
  parameter int MAX_FLOORS = elc_pkg::DEFAULT_MAX_FLOORS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [$clog2(MAX_FLOORS+1)-1:0]      eff_n_i,
  input  logic [MAX_FLOORS-1:0]                pending_i,
  input  logic [elc_pkg::FLOOR_W-1:0]          car_floor_i,
  output elc_pkg::scan_res_t                   res_o,
  output logic                                 done_o
);

  localparam int CW = $clog2(MAX_FLOORS + 1);
  localparam int IW = $clog2(MAX_FLOORS);

  logic               busy_q;
  logic [CW-1:0]      cnt_q;
  logic               done_q;
  elc_pkg::scan_res_t res_q;
  logic               bit_set;
  logic               last;

  // current floor under test
  assign bit_set = pending_i[IW'(cnt_q)];
  assign last    = (cnt_q == (eff_n_i - CW'(1)));

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // running lowest and highest-above-car
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      res_q <= '0;
    end else if (busy_q && bit_set) begin
      if (!res_q.lo_found) begin
        res_q.lo_found <= 1'b1;
        res_q.lo       <= elc_pkg::FLOOR_W'(cnt_q);
      end
      if (int'(cnt_q) >= int'(car_floor_i)) begin
        res_q.hi_found <= 1'b1;
        res_q.hi       <= elc_pkg::FLOOR_W'(cnt_q);
      end
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ===== design/elevator_look_car_controller_core.sv =====
// ----------------------------------------------------------------------------
// elevator_look_car_controller_core
// LOOK scheduler for one elevator car with a floor request bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: cmd_i selects a
//   tick (one scheduling step) or a floor request on request_floor_i.
//   Output channel (out_valid_o / out_stall_i) returns one result per item:
//   car floor, direction and the moved / served / idle / ignored flags.
//   floors_in_use_we_i writes floors_in_use_i; write only while idle.
// Sequencing:
//   a request item goes from acceptance straight to the finish step; a tick
//   first passes the scan step, in which the scanner examines one floor of
//   the request bitmap per cycle up to N, the effective floor count. The
//   result is registered in the finish step. One item is in work at a time,
//   so no new item is accepted until the last result has been loaded.
// Reset: no requests, car at floor 0, stopped, floor count 16.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module elevator_look_car_controller_core #(
  parameter int MAX_FLOORS = elc_pkg::DEFAULT_MAX_FLOORS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          floors_in_use_we_i,
  input  logic [elc_pkg::FIU_W-1:0]     floors_in_use_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [elc_pkg::FLOOR_W-1:0]   request_floor_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [elc_pkg::FLOOR_W-1:0]   car_floor_o,
  output logic [elc_pkg::DIR_W-1:0]     direction_o,
  output logic                          moved_o,
  output logic                          served_o,
  output logic                          idle_o,
  output logic                          request_ignored_o
);

  localparam int CW = $clog2(MAX_FLOORS + 1);
  localparam int IW = $clog2(MAX_FLOORS);

  elc_pkg::state_e                state_q, state_d;
  logic [MAX_FLOORS-1:0]          pend_q, pend_d;
  logic [elc_pkg::FLOOR_W-1:0]    pos_q, pos_d;
  elc_pkg::dir_e                  dir_q, dir_d;
  logic [elc_pkg::FIU_W-1:0]      fiu_q;
  logic                           cmd_q;
  logic [elc_pkg::FLOOR_W-1:0]    floor_q;

  logic                           out_valid_q;
  logic [elc_pkg::FLOOR_W-1:0]    out_floor_q;
  elc_pkg::dir_e                  out_dir_q;
  logic                           out_moved_q, out_served_q, out_idle_q, out_ign_q;

  logic [CW-1:0]                  eff_n;
  logic [CW-1:0]                  cfg_eff_n;
  logic [MAX_FLOORS-1:0]          cfg_mask;
  logic [MAX_FLOORS-1:0]          eff_mask;
  logic                           scan_start;
  logic                           scan_done;
  elc_pkg::scan_res_t             scan_res;
  logic                           out_load;
  logic                           in_accept;

  logic                           found;
  logic [elc_pkg::FLOOR_W-1:0]    target;
  logic                           moved, served, idle, ignored;

  assign eff_n     = CW'(elc_pkg::eff_floors(fiu_q, MAX_FLOORS));
  assign cfg_eff_n = CW'(elc_pkg::eff_floors(floors_in_use_i, MAX_FLOORS));
  assign in_accept = in_valid_i && !in_stall_o;

  // served-floor masks for the new and current floor count
  always_comb begin
    for (int i = 0; i < MAX_FLOORS; i++) begin
      cfg_mask[i] = (i < int'(cfg_eff_n));
      eff_mask[i] = (i < int'(eff_n));
    end
  end

  // single floor scanner, started by tick items
  elc_scan #(
    .MAX_FLOORS(MAX_FLOORS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .eff_n_i    (eff_n),
    .pending_i  (pend_q),
    .car_floor_i(pos_q),
    .res_o      (scan_res),
    .done_o     (scan_done)
  );

  // target selection from the scan summary
  always_comb begin
    found  = 1'b0;
    target = pos_q;
    case (dir_q)
      elc_pkg::DIR_UP: begin
        if (scan_res.hi_found) begin
          found  = 1'b1;
          target = scan_res.hi;
        end else if (scan_res.lo_found && (scan_res.lo <= pos_q)) begin
          found  = 1'b1;
          target = scan_res.lo;
        end
      end
      elc_pkg::DIR_DOWN: begin
        if (scan_res.lo_found && (scan_res.lo <= pos_q)) begin
          found  = 1'b1;
          target = scan_res.lo;
        end else if (scan_res.hi_found) begin
          found  = 1'b1;
          target = scan_res.hi;
        end
      end
      default: begin
        if (scan_res.lo_found) begin
          found  = 1'b1;
          target = scan_res.lo;
        end
      end
    endcase
  end

  // state update at the end of an item
  always_comb begin
    pend_d  = pend_q;
    pos_d   = pos_q;
    dir_d   = dir_q;
    moved   = 1'b0;
    served  = 1'b0;
    idle    = 1'b0;
    ignored = 1'b0;
    if (cmd_q == elc_pkg::CMD_REQUEST) begin
      if (int'(floor_q) < int'(eff_n)) begin
        pend_d[IW'(floor_q)] = 1'b1;
      end else begin
        ignored = 1'b1;
      end
    end else if (!found) begin
      dir_d = elc_pkg::DIR_STOP;
      idle  = 1'b1;
    end else begin
      if (target > pos_q) begin
        dir_d = elc_pkg::DIR_UP;
        pos_d = pos_q + elc_pkg::FLOOR_W'(1);
        moved = 1'b1;
      end else if (target < pos_q) begin
        dir_d = elc_pkg::DIR_DOWN;
        pos_d = pos_q - elc_pkg::FLOOR_W'(1);
        moved = 1'b1;
      end
      if (pend_q[IW'(pos_d)]) begin
        pend_d[IW'(pos_d)] = 1'b0;
        served             = 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    scan_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      elc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == elc_pkg::CMD_TICK) begin
            scan_start = 1'b1;
            state_d    = elc_pkg::ST_SCAN;
          end else begin
            state_d = elc_pkg::ST_FINISH;
          end
        end
      end
      elc_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = elc_pkg::ST_FINISH;
        end
      end
      elc_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = elc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = elc_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != elc_pkg::ST_IDLE);

  // control and car state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= elc_pkg::ST_IDLE;
      pend_q      <= '0;
      pos_q       <= '0;
      dir_q       <= elc_pkg::DIR_STOP;
      fiu_q       <= elc_pkg::FIU_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (floors_in_use_we_i) begin
        fiu_q  <= floors_in_use_i;
        pend_q <= pend_q & cfg_mask;
      end else if (out_load) begin
        pend_q <= pend_d;
        pos_q  <= pos_d;
        dir_q  <= dir_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_i;
      floor_q <= request_floor_i;
    end
    if (out_load) begin
      out_floor_q  <= pos_d;
      out_dir_q    <= dir_d;
      out_moved_q  <= moved;
      out_served_q <= served;
      out_idle_q   <= idle;
      out_ign_q    <= ignored;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign car_floor_o       = out_floor_q;
  assign direction_o       = out_dir_q;
  assign moved_o           = out_moved_q;
  assign served_o          = out_served_q;
  assign idle_o            = out_idle_q;
  assign request_ignored_o = out_ign_q;

  // car never leaves the bitmap
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pos_q) < MAX_FLOORS)
    else $error("car position beyond floor bitmap");

  // no request pending at an unserved floor
  a_pend_served: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q & ~eff_mask) == '0)
    else $error("request pending above floor count");

  // a new result only comes from the finishing step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == elc_pkg::ST_FINISH)
    else $error("result loaded outside finish step");

  // a served tick leaves no request at the car floor
  a_served_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && cmd_q == elc_pkg::CMD_TICK && served) |=> !pend_q[IW'(pos_q)])
    else $error("served request not cleared");

  // idle tick never reports a move or a service
  a_idle_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_idle_q && (out_moved_q || out_served_q)))
    else $error("idle result with move or service");

endmodule
